[hdl/sscp_pkg.sv]
// Shared types and constants for the S-curve stepper profile sequencer.
// No dependencies; every other file in the block refers to this package by scoped name.
package sscp_pkg;

    // Default ramp table depth and the reset value of the ramp length register.
    localparam int TABLE_DEPTH_DEF = 256;
    localparam int RAMP_LEN_RST    = 150;

    // Fixed field widths.
    localparam int CFG_W    = 9;
    localparam int OP_W     = 2;
    localparam int IDX_W    = 8;
    localparam int RELOAD_W = 16;
    localparam int POS_W    = 32;

    // Request operation codes.
    localparam logic [OP_W-1:0] OP_TABLE_WR = 2'd0;
    localparam logic [OP_W-1:0] OP_START    = 2'd1;
    localparam logic [OP_W-1:0] OP_UPDATE   = 2'd2;

    // Motion phase.
    typedef enum logic [1:0] {
        PH_STOP  = 2'd0,
        PH_ACCEL = 2'd1,
        PH_RUN   = 2'd2,
        PH_DECEL = 2'd3
    } t_phase;

    // Where the reload word of a request comes from.
    typedef enum logic [1:0] {
        RS_KEEP   = 2'd0,
        RS_TABLE  = 2'd1,
        RS_SINGLE = 2'd2
    } t_rsel;

    // Control and status carried from the sequencer to the output stage.
    typedef struct packed {
        t_rsel                rsel;
        logic [RELOAD_W-1:0]  single_reload;
        logic                 dir;
        logic                 busy;
        t_phase               phase;
        logic [POS_W-1:0]     position;
    } t_s1_ctrl;

endpackage

[hdl/stepper_scurve_profile_core.sv]
// Top level of the S-curve stepper profile sequencer; depends on sscp_pkg and its three parts.
// An accepted request is registered first in the stage register of sscp_seq and then in
// the result register of sscp_out, whose valid flag is the result handshake.
// Throughput: one request per cycle while results are taken; a held result stalls the
// request behind it. Reset (i_rst_n, synchronous, active low) clears position, move state,
// phase and handshake but not the ramp table; ramp length returns to min(150, TABLE_DEPTH).
module stepper_scurve_profile_core #(
    parameter int TABLE_DEPTH = sscp_pkg::TABLE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [sscp_pkg::CFG_W-1:0]    i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [sscp_pkg::OP_W-1:0]     i_operation,
    input  logic [sscp_pkg::IDX_W-1:0]    i_table_index,
    input  logic [sscp_pkg::RELOAD_W-1:0] i_table_value,
    input  logic signed [31:0]            i_move_steps,
    input  logic                          i_absolute_target,
    input  logic [sscp_pkg::RELOAD_W-1:0] i_single_step_reload,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [sscp_pkg::RELOAD_W-1:0] o_reload_value,
    output logic [14:0]                   o_compare_value,
    output logic                          o_direction_out,
    output logic                          o_busy_res,
    output logic [1:0]                    o_phase,
    output logic [31:0]                   o_position
);

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int LEN_W = $clog2(TABLE_DEPTH + 1);

    logic                          s1_valid;
    logic                          s1_adv;
    sscp_pkg::t_s1_ctrl            s1;
    logic                          tbl_we;
    logic [AW-1:0]                 tbl_waddr;
    logic                          tbl_re;
    logic [AW-1:0]                 tbl_raddr;
    logic [sscp_pkg::RELOAD_W-1:0] tbl_rdata;

    // Move sequencer and table addressing.
    sscp_seq #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW),
        .LEN_W       (LEN_W)
    ) u_seq (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_wdata          (i_cfg_wdata),
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_operation          (i_operation),
        .i_table_index        (i_table_index),
        .i_move_steps         (i_move_steps),
        .i_absolute_target    (i_absolute_target),
        .i_single_step_reload (i_single_step_reload),
        .i_s1_adv             (s1_adv),
        .o_s1_valid           (s1_valid),
        .o_s1                 (s1),
        .o_tbl_we             (tbl_we),
        .o_tbl_waddr          (tbl_waddr),
        .o_tbl_re             (tbl_re),
        .o_tbl_raddr          (tbl_raddr)
    );

    // Ramp table.
    sscp_table_ram #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (i_table_value),
        .i_re    (tbl_re),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_rdata)
    );

    // Reload resolution and result register.
    sscp_out u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s1_valid      (s1_valid),
        .i_s1            (s1),
        .i_tbl_rdata     (tbl_rdata),
        .o_s1_adv        (s1_adv),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_reload_value  (o_reload_value),
        .o_compare_value (o_compare_value),
        .o_direction_out (o_direction_out),
        .o_busy_res      (o_busy_res),
        .o_phase         (o_phase),
        .o_position      (o_position)
    );

endmodule

[hdl/sscp_table_ram.sv]
// Ramp table memory: one write port, one read port with registered read data.
// Depends on sscp_pkg for the reload word width.
module sscp_table_ram #(
    parameter int TABLE_DEPTH = sscp_pkg::TABLE_DEPTH_DEF,
    parameter int AW          = $clog2(TABLE_DEPTH)
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [AW-1:0]                 i_waddr,
    input  logic [sscp_pkg::RELOAD_W-1:0] i_wdata,
    input  logic                          i_re,
    input  logic [AW-1:0]                 i_raddr,
    output logic [sscp_pkg::RELOAD_W-1:0] o_rdata
);

    logic [sscp_pkg::RELOAD_W-1:0] r_mem [TABLE_DEPTH];
    logic [sscp_pkg::RELOAD_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data register holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/sscp_seq.sv]
// Profile sequencer: move setup, phase control, position and table read address.
// Depends on sscp_pkg; drives the table read and hands a control struct to sscp_out.
module sscp_seq #(
    parameter int TABLE_DEPTH = sscp_pkg::TABLE_DEPTH_DEF,
    parameter int AW          = $clog2(TABLE_DEPTH),
    parameter int LEN_W       = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [sscp_pkg::CFG_W-1:0]    i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [sscp_pkg::OP_W-1:0]     i_operation,
    input  logic [sscp_pkg::IDX_W-1:0]    i_table_index,
    input  logic [sscp_pkg::POS_W-1:0]    i_move_steps,
    input  logic                          i_absolute_target,
    input  logic [sscp_pkg::RELOAD_W-1:0] i_single_step_reload,
    input  logic                          i_s1_adv,
    output logic                          o_s1_valid,
    output sscp_pkg::t_s1_ctrl            o_s1,
    output logic                          o_tbl_we,
    output logic [AW-1:0]                 o_tbl_waddr,
    output logic                          o_tbl_re,
    output logic [AW-1:0]                 o_tbl_raddr
);

    localparam int RST_LEN = (sscp_pkg::RAMP_LEN_RST > TABLE_DEPTH) ? TABLE_DEPTH
                                                                     : sscp_pkg::RAMP_LEN_RST;

    // Control state.
    logic [31:0]          r_position, n_position;
    logic [31:0]          r_counter,  n_counter;
    logic [31:0]          r_remain,   n_remain;
    logic [LEN_W-1:0]     r_accel,    n_accel;
    logic [31:0]          r_decel,    n_decel;
    sscp_pkg::t_phase     r_phase,    n_phase;
    logic                 r_dir,      n_dir;
    logic                 r_moving,   n_moving;
    logic [LEN_W-1:0]     r_len,      n_len;
    logic                 r_s1_valid, n_s1_valid;
    sscp_pkg::t_s1_ctrl   r_s1,       n_s1;

    logic                 accept;
    logic [31:0]          cfg_ext;
    logic [31:0]          cfg_eff;
    logic [31:0]          len_ext;
    logic [31:0]          len_m1;
    logic [31:0]          idx_ext;
    logic [31:0]          diff_fwd;
    logic [31:0]          diff_rev;
    logic                 neg;
    logic [31:0]          mag;
    logic                 mag_short;
    logic [31:0]          cnt_inc;
    logic [31:0]          rem_m1;
    logic                 acc_lt;
    logic                 dec_ge;
    logic                 len_ge;
    logic                 rem_more;
    logic                 rem_clamp;
    logic [AW-1:0]        decel_addr;
    logic                 cnt_clamp;
    logic [AW-1:0]        accel_end_addr;
    sscp_pkg::t_rsel      rsel;
    logic [AW-1:0]        rd_addr;

    // A request enters when the stage ahead is empty or moving on.
    assign o_in_ready = !r_s1_valid || i_s1_adv;
    assign accept     = i_in_valid && o_in_ready;

    // Ramp length clamped into one to the table depth when it is written.
    assign cfg_ext = 32'(i_cfg_wdata);
    always_comb begin
        if (cfg_ext == 32'd0) begin
            cfg_eff = 32'd1;
        end else if (cfg_ext > 32'(TABLE_DEPTH)) begin
            cfg_eff = 32'(TABLE_DEPTH);
        end else begin
            cfg_eff = cfg_ext;
        end
    end
    assign n_len = i_cfg_we ? LEN_W'(cfg_eff) : r_len;

    assign len_ext = 32'(r_len);
    assign len_m1  = len_ext - 32'd1;
    assign idx_ext = 32'(i_table_index);

    // Move magnitude and direction; both subtraction orders run side by side.
    assign diff_fwd = i_move_steps - r_position;
    assign diff_rev = r_position - i_move_steps;
    always_comb begin
        if (i_absolute_target) begin
            neg = diff_fwd[31];
            mag = neg ? diff_rev : diff_fwd;
        end else begin
            neg = i_move_steps[31];
            mag = neg ? (32'd0 - i_move_steps) : i_move_steps;
        end
    end
    assign mag_short = (mag <= {len_ext[30:0], 1'b0});

    // Step conditions for the next counter value.
    assign cnt_inc   = r_counter + 32'd1;
    assign rem_m1    = r_remain - 32'd1;
    assign acc_lt    = (cnt_inc < 32'(r_accel));
    assign dec_ge    = (cnt_inc >= r_decel);
    assign len_ge    = (cnt_inc >= len_ext);
    assign rem_more  = (r_remain > 32'd1);
    assign rem_clamp = (r_remain > 32'(TABLE_DEPTH));
    assign decel_addr = rem_clamp ? AW'(TABLE_DEPTH - 1) : rem_m1[AW-1:0];

    // When the ramp length changes under a running move, acceleration can last
    // past the table, so the entry read on leaving it is clamped to the last one.
    assign cnt_clamp      = (r_counter >= 32'(TABLE_DEPTH));
    assign accel_end_addr = cnt_clamp ? AW'(TABLE_DEPTH - 1) : r_counter[AW-1:0];

    // Next state of the move.
    always_comb begin
        n_position = r_position;
        n_counter  = r_counter;
        n_remain   = r_remain;
        n_accel    = r_accel;
        n_decel    = r_decel;
        n_phase    = r_phase;
        n_dir      = r_dir;
        n_moving   = r_moving;
        if (accept) begin
            case (i_operation)
                sscp_pkg::OP_START: begin
                    n_dir     = neg;
                    n_counter = 32'd0;
                    n_remain  = mag;
                    if (mag == 32'd0) begin
                        n_accel  = '0;
                        n_decel  = 32'd0;
                        n_phase  = sscp_pkg::PH_STOP;
                        n_moving = 1'b0;
                    end else if (mag == 32'd1) begin
                        n_accel  = LEN_W'(1);
                        n_decel  = 32'd1;
                        n_phase  = sscp_pkg::PH_DECEL;
                        n_moving = 1'b1;
                    end else begin
                        if (mag_short) begin
                            n_accel = LEN_W'(mag >> 1);
                            n_decel = mag >> 1;
                        end else begin
                            n_accel = r_len;
                            n_decel = mag - len_ext;
                        end
                        n_phase  = sscp_pkg::PH_ACCEL;
                        n_moving = 1'b1;
                    end
                end
                sscp_pkg::OP_UPDATE: begin
                    if (r_phase == sscp_pkg::PH_STOP) begin
                        n_counter = 32'd0;
                        n_moving  = 1'b0;
                    end else begin
                        n_counter  = cnt_inc;
                        n_remain   = rem_m1;
                        n_position = r_dir ? (r_position - 32'd1) : (r_position + 32'd1);
                        case (r_phase)
                            sscp_pkg::PH_ACCEL: begin
                                if (acc_lt) begin
                                    n_phase = sscp_pkg::PH_ACCEL;
                                end else if (dec_ge) begin
                                    n_phase = sscp_pkg::PH_DECEL;
                                end else if (len_ge) begin
                                    n_phase = sscp_pkg::PH_RUN;
                                end
                            end
                            sscp_pkg::PH_RUN: begin
                                if (dec_ge) begin
                                    n_phase = sscp_pkg::PH_DECEL;
                                end
                            end
                            sscp_pkg::PH_DECEL: begin
                                if (!rem_more) begin
                                    n_phase = sscp_pkg::PH_STOP;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Reload source and table read address of the request.
    always_comb begin
        rsel    = sscp_pkg::RS_KEEP;
        rd_addr = '0;
        case (i_operation)
            sscp_pkg::OP_START: begin
                if (mag == 32'd1) begin
                    rsel = sscp_pkg::RS_SINGLE;
                end else if (mag != 32'd0) begin
                    rsel = sscp_pkg::RS_TABLE;
                end
            end
            sscp_pkg::OP_UPDATE: begin
                case (r_phase)
                    sscp_pkg::PH_ACCEL: begin
                        if (acc_lt) begin
                            rsel    = sscp_pkg::RS_TABLE;
                            rd_addr = cnt_inc[AW-1:0];
                        end else if (dec_ge) begin
                            rsel    = sscp_pkg::RS_TABLE;
                            rd_addr = accel_end_addr;
                        end else if (len_ge) begin
                            rsel    = sscp_pkg::RS_TABLE;
                            rd_addr = len_m1[AW-1:0];
                        end
                    end
                    sscp_pkg::PH_RUN: begin
                        if (dec_ge) begin
                            rsel    = sscp_pkg::RS_TABLE;
                            rd_addr = len_m1[AW-1:0];
                        end
                    end
                    sscp_pkg::PH_DECEL: begin
                        if (rem_more) begin
                            rsel    = sscp_pkg::RS_TABLE;
                            rd_addr = decel_addr;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    // Table port control. A write and a later read of the same entry land on
    // different edges, so the read always sees the written word.
    assign o_tbl_we    = accept && (i_operation == sscp_pkg::OP_TABLE_WR)
                         && (idx_ext < 32'(TABLE_DEPTH));
    assign o_tbl_waddr = idx_ext[AW-1:0];
    assign o_tbl_re    = accept;
    assign o_tbl_raddr = rd_addr;

    // Stage register toward the output side.
    assign n_s1_valid = accept || (r_s1_valid && !i_s1_adv);
    always_comb begin
        n_s1               = r_s1;
        if (accept) begin
            n_s1.rsel          = rsel;
            n_s1.single_reload = i_single_step_reload;
            n_s1.dir           = n_dir;
            n_s1.busy          = n_moving;
            n_s1.phase         = n_phase;
            n_s1.position      = n_position;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position <= '0;
            r_counter  <= '0;
            r_remain   <= '0;
            r_accel    <= '0;
            r_decel    <= '0;
            r_phase    <= sscp_pkg::PH_STOP;
            r_dir      <= 1'b0;
            r_moving   <= 1'b0;
            r_len      <= LEN_W'(RST_LEN);
            r_s1_valid <= 1'b0;
        end else begin
            r_position <= n_position;
            r_counter  <= n_counter;
            r_remain   <= n_remain;
            r_accel    <= n_accel;
            r_decel    <= n_decel;
            r_phase    <= n_phase;
            r_dir      <= n_dir;
            r_moving   <= n_moving;
            r_len      <= n_len;
            r_s1_valid <= n_s1_valid;
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        r_s1 <= n_s1;
    end

    assign o_s1_valid = r_s1_valid;
    assign o_s1       = r_s1;

`ifndef SYNTHESIS
    // An idle motor always sits in the stop phase.
    a_idle_is_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_moving |-> (r_phase == sscp_pkg::PH_STOP))
        else $error("sscp_seq: not moving but phase is not stop");

    // Acceleration always has a nonzero length.
    a_accel_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == sscp_pkg::PH_ACCEL) |-> (r_accel != '0))
        else $error("sscp_seq: accelerating with a zero length");

    // Deceleration always has steps left to make.
    a_decel_remain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == sscp_pkg::PH_DECEL) |-> (r_remain != 32'd0))
        else $error("sscp_seq: decelerating with no steps left");

    // A timer update outside stop moves the position.
    a_update_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_operation == sscp_pkg::OP_UPDATE) && (r_phase != sscp_pkg::PH_STOP))
        |=> (r_position != $past(r_position)))
        else $error("sscp_seq: update step did not move the position");
`endif

endmodule

[hdl/sscp_out.sv]
// Output stage: resolves the reload word from the table read and drives the result register.
// Depends on sscp_pkg for the control struct and reload source codes.
module sscp_out (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s1_valid,
    input  sscp_pkg::t_s1_ctrl            i_s1,
    input  logic [sscp_pkg::RELOAD_W-1:0] i_tbl_rdata,
    output logic                          o_s1_adv,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [sscp_pkg::RELOAD_W-1:0] o_reload_value,
    output logic [sscp_pkg::RELOAD_W-2:0] o_compare_value,
    output logic                          o_direction_out,
    output logic                          o_busy_res,
    output logic [1:0]                    o_phase,
    output logic [sscp_pkg::POS_W-1:0]    o_position
);

    logic [sscp_pkg::RELOAD_W-1:0] r_reload, n_reload;
    logic                          r_out_valid, n_out_valid;
    logic [sscp_pkg::RELOAD_W-1:0] r_o_reload;
    logic                          r_o_dir;
    logic                          r_o_busy;
    sscp_pkg::t_phase              r_o_phase;
    logic [sscp_pkg::POS_W-1:0]    r_o_position;
    logic                          load;

    // The result register takes a new request when empty or being drained.
    assign o_s1_adv = !r_out_valid || i_out_ready;
    assign load     = i_s1_valid && o_s1_adv;

    // Current reload word: kept, taken from the table, or the one-step word.
    always_comb begin
        case (i_s1.rsel)
            sscp_pkg::RS_TABLE:  n_reload = i_tbl_rdata;
            sscp_pkg::RS_SINGLE: n_reload = i_s1.single_reload;
            default:             n_reload = r_reload;
        endcase
    end

    assign n_out_valid = load || (r_out_valid && !i_out_ready);

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reload    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_reload <= n_reload;
            end
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_o_reload   <= n_reload;
            r_o_dir      <= i_s1.dir;
            r_o_busy     <= i_s1.busy;
            r_o_phase    <= i_s1.phase;
            r_o_position <= i_s1.position;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_reload_value  = r_o_reload;
    assign o_compare_value = r_o_reload[sscp_pkg::RELOAD_W-1:1];
    assign o_direction_out = r_o_dir;
    assign o_busy_res      = r_o_busy;
    assign o_phase         = r_o_phase;
    assign o_position      = r_o_position;

endmodule
